[rtl/core/oss_pkg.sv]
// ----------------------------------------------------------------------------
// Order-statistic sorted set package
// Shared constants, codes and beat types for the sorted set core.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_VALUE_BITS = 32;

  // Fixed field widths of the request and response beats.
  localparam int VALUE_W = 32;
  localparam int RANK_W  = 6;
  localparam int STAT_W  = 2;

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes.
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  typedef struct packed {
    logic                      operation;
    logic signed [VALUE_W-1:0] value;
    logic        [RANK_W-1:0]  position;
  } oss_req_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [STAT_W-1:0] status;
  } oss_rsp_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic do_insert;
    logic do_delete;
  } oss_ctrl_t;

endpackage

[rtl/core/oss_stream_if.sv]
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// Carries one payload beat per cycle under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface oss_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/oss_cell.sv]
// ----------------------------------------------------------------------------
// Sorted set cell
// Holds one entry; compares it with the broadcast key and shifts left/right.
// ----------------------------------------------------------------------------
module oss_cell import oss_pkg::*; #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int CNT_W      = 7
) (
  input  logic                         clk,
  input  oss_ctrl_t                    ctrl,
  input  logic signed [VALUE_BITS-1:0] key,
  input  logic        [RANK_W-1:0]     position,
  input  logic        [CNT_W-1:0]      count,
  input  logic signed [VALUE_BITS-1:0] left_val,
  input  logic                         left_ge,
  input  logic signed [VALUE_BITS-1:0] right_val,
  output logic signed [VALUE_BITS-1:0] val,
  output logic                         ge,
  output logic                         gt
);

  localparam int IX_W = CNT_W + RANK_W;

  logic occupied;
  logic at_or_past_pos;

  assign occupied       = IX_W'(IDX) < IX_W'(count);
  assign ge             = occupied && (val >= key);
  assign gt             = occupied && (val > key);
  assign at_or_past_pos = IX_W'(IDX) >= IX_W'(position);

  // On insert, cells ahead of the slot keep their entry, the slot takes the key
  // and the cells behind shift right; a delete shifts left from the position.
  always_ff @(posedge clk) begin
    if (ctrl.do_insert && !ge) begin
      val <= left_ge ? key : left_val;
    end else if (ctrl.do_delete && at_or_past_pos) begin
      val <= right_val;
    end
  end

endmodule

[rtl/core/oss_rank_enc.sv]
// ----------------------------------------------------------------------------
// Rank encoder
// Turns the thermometer of greater-than flags into a binary count.
// ----------------------------------------------------------------------------
module oss_rank_enc import oss_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = 7
) (
  input  logic [CAPACITY-1:0] gt,
  output logic [CNT_W-1:0]    rank
);

  // The entries are sorted, so the flags form a run of ones from cell 0.
  // The last one of that run marks the count; each cell contributes its
  // position plus one when it is that last one.
  always_comb begin
    logic [CNT_W-1:0] acc;
    logic             edge_hit;
    acc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      edge_hit = gt[i] && ((i == CAPACITY - 1) || !gt[(i + 1) % CAPACITY]);
      if (edge_hit) begin
        acc = acc | CNT_W'(i + 1);
      end
    end
    rank = acc;
  end

endmodule

[rtl/core/order_statistic_sorted_set.sv]
// ----------------------------------------------------------------------------
// Order-statistic sorted set
// Bounded set of signed values in descending order with rank reporting.
// ----------------------------------------------------------------------------
//
//   Channel | Dir | Payload                         | Beat
//   --------+-----+---------------------------------+-----------------------
//   req     | in  | operation, value, position      | one insert or delete
//   rsp     | out | rank, status                    | one result per request
//
// A request beat is captured into an issue register. From there it is
// executed by the cell chain: every cell compares its entry with the key in
// parallel, the chain shifts by one place, and the result is loaded into the
// response register. With the response side free the block sustains one beat
// per cycle, taking a new request while the last one executes.
// A stalled response holds the executing beat in the issue register, and the
// request side stalls only once that register is also occupied.
// Reset clears the entry count and both valid flags; the entries themselves
// are never cleared since only occupied cells are ever compared or read.
//
module order_statistic_sorted_set import oss_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic         clk,
  input  logic         rst,
  oss_stream_if.sink   req,
  oss_stream_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IX_W  = CNT_W + RANK_W;

  // Issue register: the request beat waiting for the cell chain.
  logic                         busy;
  logic                         op;
  logic signed [VALUE_BITS-1:0] key;
  logic        [RANK_W-1:0]     position;

  // Number of occupied cells.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Response register.
  logic     rsp_valid;
  oss_rsp_t rsp_data;
  oss_rsp_t rsp_next;

  logic      execute;
  logic      full;
  logic      in_range;
  oss_ctrl_t ctrl;

  logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic        [CAPACITY-1:0]   cell_ge;
  logic        [CAPACITY-1:0]   cell_gt;
  logic        [CNT_W-1:0]      greater;

  // The beat in the issue register executes as soon as the response
  // register is empty or being emptied in this cycle.
  assign execute   = busy && (!rsp_valid || rsp.ready);
  assign req.ready = !busy || execute;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign full     = count == CNT_W'(CAPACITY);
  assign in_range = IX_W'(position) < IX_W'(count);

  assign ctrl.do_insert = execute && (op == OP_INSERT) && !full;
  assign ctrl.do_delete = execute && (op == OP_DELETE) && in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.ready) begin
      busy <= req.valid;
    end
  end

  // The key keeps the low VALUE_BITS bits of the value, sign-extended when
  // the stored width is larger than the field.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= req.data.operation;
      key      <= VALUE_BITS'(req.data.value);
      position <= req.data.position;
    end
  end

  // The cell chain. Cell 0 sees the key as its left neighbor with a set
  // greater-or-equal flag, so it takes the key when it is the slot. The
  // last cell refills from itself on a delete; that entry falls out of use.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left_val;
    logic                         left_ge;
    logic signed [VALUE_BITS-1:0] right_val;

    if (i == 0) begin : g_head
      assign left_val = key;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_ge  = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    oss_cell #(
      .IDX        (i),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (key),
      .position  (position),
      .count     (count),
      .left_val  (left_val),
      .left_ge   (left_ge),
      .right_val (right_val),
      .val       (cell_val[i]),
      .ge        (cell_ge[i]),
      .gt        (cell_gt[i])
    );
  end

  oss_rank_enc #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_rank_enc (
    .gt   (cell_gt),
    .rank (greater)
  );

  // Result of the executing beat and the new entry count.
  always_comb begin
    count_next = count;
    rsp_next   = '{rank: position, status: STAT_DONE};
    if (op == OP_INSERT) begin
      if (full) begin
        rsp_next = '{rank: '0, status: STAT_FULL};
      end else begin
        rsp_next   = '{rank: RANK_W'(greater), status: STAT_DONE};
        count_next = count + CNT_W'(1);
      end
    end else if (!in_range) begin
      rsp_next.status = STAT_RANGE;
    end else begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (execute) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (execute) begin
      rsp_data <= rsp_next;
    end
  end

endmodule
